// ----- sv/ifl_pkg.sv -----
// Shared types and constants for the IMU frame transform / lever-arm block.
// No dependencies; imported by every module of the block.
package ifl_pkg;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROW0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ARM   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN  = 3'd4;

  // Smoothing gain, Q1.16
  localparam int GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

  // Fraction bits of the vector format and micro-seconds per second
  localparam int VEC_FRAC = 16;
  localparam int MICRO_W  = 20;
  localparam logic [MICRO_W-1:0] MICROS_PER_SEC = 20'd1000000;

  // Rounding shift applied after a lane product
  typedef enum logic [1:0] {
    SH_ROT,
    SH_ARM,
    SH_VEC
  } shift_t;

  // Per-step lane control
  typedef struct packed {
    logic   issue;
    logic   first;
    logic   neg;
    shift_t sh;
  } lane_ctl_t;

endpackage

// ----- sv/ifl_lane.sv -----
// One multiply-accumulate lane: registered product, round-half-away shift, accumulate,
// saturate. Depends on ifl_pkg.
module ifl_lane #(
  parameter int VB  = 32,
  parameter int CB  = 16,
  parameter int OPW = 34
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ifl_pkg::lane_ctl_t     ctl,
  input  logic signed [OPW-1:0]  op_a,
  input  logic signed [OPW-1:0]  op_b,
  input  logic signed [VB-1:0]   bias,
  output logic signed [VB-1:0]   res
);
  import ifl_pkg::*;

  localparam int PW = 2*OPW + 1;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] MAXV = (AW'(1) <<< (VB-1)) - AW'(1);
  localparam logic signed [AW-1:0] MINV = -MAXV - AW'(1);

  logic signed [2*OPW-1:0] prod;
  lane_ctl_t               ctl_d;
  logic signed [AW-1:0]    acc;
  logic signed [AW-1:0]    acc_next;
  logic signed [PW-1:0]    p_ext;
  logic signed [PW-1:0]    half;
  logic signed [PW-1:0]    rnd;
  logic signed [PW-1:0]    shr;
  logic [4:0]              sh_amt;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
    end else begin
      ctl_d <= ctl;
    end
    if (ctl.issue) begin
      prod <= op_a * op_b;
    end
  end

  // rounding shift and accumulate
  always_comb begin
    case (ctl_d.sh)
      SH_ROT:  sh_amt = 5'(CB - 2);
      SH_ARM:  sh_amt = 5'(CB - 4);
      SH_VEC:  sh_amt = 5'(VEC_FRAC);
      default: sh_amt = 5'(VEC_FRAC);
    endcase
    p_ext = PW'(prod);
    half  = PW'(1) <<< (sh_amt - 5'd1);
    // half away from zero: negative products take one off before the floor shift
    rnd   = p_ext + half - PW'(signed'({1'b0, p_ext[PW-1]}));
    shr   = rnd >>> sh_amt;
    acc_next = (ctl_d.first ? AW'(bias) : acc) + (ctl_d.neg ? -AW'(shr) : AW'(shr));
  end

  always_ff @(posedge clk) begin
    if (ctl_d.issue) begin
      acc <= acc_next;
    end
  end

  // saturate to the vector width
  always_comb begin
    if (acc > MAXV) begin
      res = MAXV[VB-1:0];
    end else if (acc < MINV) begin
      res = MINV[VB-1:0];
    end else begin
      res = acc[VB-1:0];
    end
  end

endmodule

// ----- sv/ifl_div.sv -----
// Rate-over-time unit: |diff| * 1e6 + dt/2, restoring division by dt one bit a cycle,
// signed and saturated result. Depends on ifl_pkg.
module ifl_div #(
  parameter int VB = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [VB:0]   diff,
  input  logic [63:0]          dt,
  output logic                 busy,
  output logic signed [VB-1:0] quot
);
  import ifl_pkg::*;

  localparam int MW = VB + 1 + MICRO_W;
  localparam int NW = ((MW > 64) ? MW : 64) + 1;
  localparam int CW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIMP = (NW'(1) << (VB-1)) - NW'(1);
  localparam logic [NW-1:0] LIMN = NW'(1) << (VB-1);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_ADD, D_RUN} dstate_t;

  dstate_t       st;
  logic [VB:0]   mag;
  logic          neg;
  logic [63:0]   dvs;
  logic [NW-1:0] num;
  logic [64:0]   rem;
  logic [CW-1:0] cnt;
  logic [MW-1:0] scaled;
  logic [64:0]   rem_s;
  logic          ge;
  logic [64:0]   rem_n;

  // one quotient bit per cycle
  always_comb begin
    scaled = MW'(mag) * MW'(MICROS_PER_SEC);
    rem_s  = {rem[63:0], num[NW-1]};
    ge     = rem_s >= {1'b0, dvs};
    rem_n  = ge ? rem_s - {1'b0, dvs} : rem_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
    end else begin
      case (st)
        D_IDLE: begin
          if (start) begin
            mag <= diff[VB] ? (VB+1)'(-diff) : (VB+1)'(diff);
            neg <= diff[VB];
            dvs <= dt;
            st  <= D_MUL;
          end
        end
        D_MUL: begin
          num <= NW'(scaled);
          st  <= D_ADD;
        end
        D_ADD: begin
          num <= num + NW'(dvs[63:1]);
          rem <= '0;
          cnt <= '0;
          st  <= D_RUN;
        end
        D_RUN: begin
          rem <= rem_n;
          num <= {num[NW-2:0], ge};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NW - 1)) begin
            st <= D_IDLE;
          end
        end
        default: st <= D_IDLE;
      endcase
    end
  end

  assign busy = (st != D_IDLE);

  // sign and saturate
  always_comb begin
    if (neg) begin
      quot = (num > LIMN) ? VB'(-LIMN) : VB'(-num);
    end else begin
      quot = (num > LIMP) ? VB'(LIMP) : VB'(num);
    end
  end

endmodule

// ----- sv/ifl_merge.sv -----
// Merge stage: rotated acceleration plus tangential and centripetal terms, saturated.
// Depends on ifl_pkg.
module ifl_merge #(
  parameter int VB = 32
) (
  input  logic signed [VB-1:0] acc_rot [3],
  input  logic signed [VB-1:0] tang    [3],
  input  logic signed [VB-1:0] centr   [3],
  output logic signed [VB-1:0] sum     [3]
);
  import ifl_pkg::*;

  localparam int SW = VB + 2;
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (VB-1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [SW-1:0] tot [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = SW'(acc_rot[i]) + SW'(tang[i]) + SW'(centr[i]);
      if (tot[i] > MAXV) begin
        sum[i] = MAXV[VB-1:0];
      end else if (tot[i] < MINV) begin
        sum[i] = MINV[VB-1:0];
      end else begin
        sum[i] = tot[i][VB-1:0];
      end
    end
  end

endmodule

// ----- sv/imu_frame_transform_lever_arm_core.sv -----
// Top level of the IMU frame transform with lever-arm compensation.
// Depends on ifl_pkg, ifl_lane, ifl_div and ifl_merge.
//
// Usage:
//  - Input channel in_valid/in_ready carries one gyro vector, one accelerometer
//    vector and a microsecond stamp. Output channel out_valid/out_ready returns the
//    camera-frame rate, the lever-arm corrected acceleration and the stamp.
//  - Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data): three
//    rotation rows, the lever arm and the smoothing gain. Write only while idle.
//  - Three lanes, one per axis, each with one multiplier, step through rotation,
//    cross products and smoothing; one divider per lane forms angular acceleration.
//  - The divider retires one quotient bit per cycle over 65 bits. One item is in work
//    at a time, so the next item is taken only once the previous one has been passed
//    to the output step.
//  - A finished result sits in the output register; the next item is accepted while
//    it waits. If the receiver stalls, the following result holds inside the block
//    until the output register frees.
//  - Synchronous reset restores the identity rotation, zero lever arm, a gain of
//    one half and clears the previous rate, angular acceleration and time.
module imu_frame_transform_lever_arm_core #(
  parameter int VECTOR_BITS = 32,
  parameter int COEF_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             rate_x,
  input  logic signed [31:0]             rate_y,
  input  logic signed [31:0]             rate_z,
  input  logic signed [31:0]             accel_x,
  input  logic signed [31:0]             accel_y,
  input  logic signed [31:0]             accel_z,
  input  logic [63:0]                    time_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             cam_rate_x,
  output logic signed [31:0]             cam_rate_y,
  output logic signed [31:0]             cam_rate_z,
  output logic signed [31:0]             cam_accel_x,
  output logic signed [31:0]             cam_accel_y,
  output logic signed [31:0]             cam_accel_z,
  output logic [63:0]                    stamp_us,
  input  logic                           cfg_wr_en,
  input  logic [ifl_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [3*COEF_BITS-1:0]         cfg_data
);
  import ifl_pkg::*;

  localparam int VB    = VECTOR_BITS;
  localparam int CB    = COEF_BITS;
  localparam int OPW   = (VB + 2 > 32) ? VB + 2 : 32;
  localparam int REG_W = 3 * CB;

  typedef enum logic [3:0] {
    S_IDLE, S_ROTR, S_ROTA, S_INNER, S_CENTR, S_DIVW, S_ALPHA, S_TANG, S_OUT
  } state_t;

  state_t                state;
  logic [2:0]            cnt;
  logic [2:0]            n_steps;
  logic [REG_W-1:0]      rows [3];
  logic [REG_W-1:0]      lever;
  logic [GAIN_W-1:0]     gain;
  logic [GAIN_W-1:0]     gain_eff;
  logic signed [31:0]    in_rate [3];
  logic signed [31:0]    in_acc  [3];
  logic [63:0]           tstamp;
  logic [63:0]           prev_time;
  logic [63:0]           d_reg;
  logic                  skip;
  logic signed [VB-1:0]  omega [3];
  logic signed [VB-1:0]  acc_rot [3];
  logic signed [VB-1:0]  inner [3];
  logic signed [VB-1:0]  centr [3];
  logic signed [VB-1:0]  alpha [3];
  logic signed [VB-1:0]  tang [3];
  logic signed [VB-1:0]  prev_rate [3];
  logic signed [VB-1:0]  prev_alpha [3];
  logic signed [VB-1:0]  lane_res [3];
  logic signed [VB-1:0]  raw [3];
  logic signed [VB-1:0]  fin [3];
  logic signed [CB-1:0]  arm_c [3];
  logic                  div_busy [3];
  logic                  any_busy;
  logic                  div_start;
  logic [1:0]            kk;

  function automatic logic signed [CB-1:0] coef_of(input logic [REG_W-1:0] r,
                                                   input logic [1:0] k);
    coef_of = r[k*CB +: CB];
  endfunction

  function automatic logic [31:0] to_out(input logic signed [VB-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    to_out = w[31:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign gain_eff  = (gain > GAIN_ONE) ? GAIN_ONE : gain;
  assign kk        = (cnt < 3'd3) ? cnt[1:0] : 2'd0;
  assign div_start = (state == S_ROTA) && (cnt == 3'd0);
  assign any_busy  = div_busy[0] | div_busy[1] | div_busy[2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      arm_c[k] = coef_of(lever, 2'(k));
    end
  end

  // multiply steps per phase
  always_comb begin
    case (state)
      S_ROTR, S_ROTA:         n_steps = 3'd3;
      S_INNER, S_CENTR, S_TANG: n_steps = 3'd2;
      S_ALPHA:                n_steps = 3'd1;
      default:                n_steps = 3'd0;
    endcase
  end

  // lanes: one per axis, with a divider each
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    lane_ctl_t             ctl;
    logic signed [OPW-1:0] op_a;
    logic signed [OPW-1:0] op_b;
    logic signed [VB-1:0]  bias;

    always_comb begin
      ctl.issue = (cnt < n_steps);
      ctl.first = (cnt == 3'd0);
      ctl.neg   = 1'b0;
      ctl.sh    = SH_VEC;
      op_a      = '0;
      op_b      = '0;
      bias      = '0;
      case (state)
        S_ROTR, S_ROTA: begin
          ctl.sh = SH_ROT;
          op_a   = OPW'(coef_of(rows[i], kk));
          op_b   = (state == S_ROTR) ? OPW'(in_rate[kk]) : OPW'(in_acc[kk]);
        end
        // cross products: component i = a[J]*b[K] - a[K]*b[J]
        S_INNER: begin
          ctl.sh  = SH_ARM;
          ctl.neg = (cnt != 3'd0);
          op_a    = (cnt == 3'd0) ? OPW'(omega[J]) : OPW'(omega[K]);
          op_b    = (cnt == 3'd0) ? OPW'(arm_c[K]) : OPW'(arm_c[J]);
        end
        S_CENTR: begin
          ctl.neg = (cnt != 3'd0);
          op_a    = (cnt == 3'd0) ? OPW'(omega[J]) : OPW'(omega[K]);
          op_b    = (cnt == 3'd0) ? OPW'(inner[K]) : OPW'(inner[J]);
        end
        S_ALPHA: begin
          op_a = OPW'(signed'({1'b0, gain_eff}));
          op_b = OPW'(raw[i]) - OPW'(prev_alpha[i]);
          bias = prev_alpha[i];
        end
        S_TANG: begin
          ctl.sh  = SH_ARM;
          ctl.neg = (cnt != 3'd0);
          op_a    = (cnt == 3'd0) ? OPW'(alpha[J]) : OPW'(alpha[K]);
          op_b    = (cnt == 3'd0) ? OPW'(arm_c[K]) : OPW'(arm_c[J]);
        end
        default: ctl.issue = 1'b0;
      endcase
    end

    ifl_lane #(.VB(VB), .CB(CB), .OPW(OPW)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .op_a (op_a),
      .op_b (op_b),
      .bias (bias),
      .res  (lane_res[i])
    );

    ifl_div #(.VB(VB)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .diff  ((VB+1)'(omega[i]) - (VB+1)'(prev_rate[i])),
      .dt    (d_reg),
      .busy  (div_busy[i]),
      .quot  (raw[i])
    );
  end

  ifl_merge #(.VB(VB)) u_merge (
    .acc_rot (acc_rot),
    .tang    (tang),
    .centr   (centr),
    .sum     (fin)
  );

  // sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rows[i]       <= REG_W'(1) << (i*CB + CB - 2);
        prev_rate[i]  <= '0;
        prev_alpha[i] <= '0;
      end
      lever     <= '0;
      gain      <= GAIN_RESET;
      prev_time <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROW0: rows[0] <= cfg_data;
          REG_ROW1: rows[1] <= cfg_data;
          REG_ROW2: rows[2] <= cfg_data;
          REG_ARM:  lever   <= cfg_data;
          REG_GAIN: gain    <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      // the output step reloads the register itself when it frees
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_rate[0] <= rate_x;
            in_rate[1] <= rate_y;
            in_rate[2] <= rate_z;
            in_acc[0]  <= accel_x;
            in_acc[1]  <= accel_y;
            in_acc[2]  <= accel_z;
            tstamp     <= time_us;
            d_reg      <= time_us - prev_time;
            skip       <= (prev_time == 64'd0) || (time_us == prev_time);
            prev_time  <= time_us;
            cnt        <= '0;
            state      <= S_ROTR;
          end
        end
        S_DIVW: begin
          if (!any_busy) begin
            cnt   <= '0;
            state <= S_ALPHA;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            cam_rate_x  <= to_out(omega[0]);
            cam_rate_y  <= to_out(omega[1]);
            cam_rate_z  <= to_out(omega[2]);
            cam_accel_x <= to_out(fin[0]);
            cam_accel_y <= to_out(fin[1]);
            cam_accel_z <= to_out(fin[2]);
            stamp_us    <= tstamp;
            out_valid   <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              prev_rate[i]  <= omega[i];
              prev_alpha[i] <= alpha[i];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          // multiply phases: issue steps, let the lane drain, then capture
          if (cnt == n_steps + 3'd1) begin
            cnt <= '0;
            for (int i = 0; i < 3; i++) begin
              case (state)
                S_ROTR:  omega[i]   <= lane_res[i];
                S_ROTA:  acc_rot[i] <= lane_res[i];
                S_INNER: inner[i]   <= lane_res[i];
                S_CENTR: centr[i]   <= lane_res[i];
                S_ALPHA: alpha[i]   <= skip ? '0 : lane_res[i];
                S_TANG:  tang[i]    <= lane_res[i];
                default: ;
              endcase
            end
            case (state)
              S_ROTR:  state <= S_ROTA;
              S_ROTA:  state <= S_INNER;
              S_INNER: state <= S_CENTR;
              S_CENTR: state <= S_DIVW;
              S_ALPHA: state <= S_TANG;
              S_TANG:  state <= S_OUT;
              default: state <= S_IDLE;
            endcase
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
      endcase
    end
  end

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && skip) |-> (alpha[0] == '0 && alpha[1] == '0 && alpha[2] == '0))
    else $error("angular acceleration not zero for a first or repeated stamp");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALPHA) |-> !any_busy)
    else $error("smoothing started before the dividers finished");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result shown outside the output step");

endmodule
